// File: hdl/ufs_pkg.sv
// Shared constants for the disjoint-set table with set sizes.
package ufs_pkg;

    localparam int DEFAULT_NUM_ELEMENTS = 1024;
    localparam int INDEX_WIDTH          = 10;
    localparam int SIZE_WIDTH           = 11;
    localparam int RANK_WIDTH           = 4;
    localparam logic [RANK_WIDTH-1:0] RANK_MAX = 4'd15;

    localparam logic ACT_UNION = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

endpackage

// File: hdl/ufs_mem.sv
// Simple dual-port synchronous RAM with a registered read port.
module ufs_mem #(
    parameter int DEPTH = ufs_pkg::DEFAULT_NUM_ELEMENTS,
    parameter int DW    = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/union_find_with_set_sizes_top.sv
// Disjoint-set union table by rank with path compression and per-root member counts.
// Union item: each root search follows the links up to the root, then makes one compression
// write per node below the root. Two distinct roots are then linked with two writes; the
// result is the joined size, or the existing size if already joined. The next item is taken
// only once the result is in the output register. Depth stays within log2(NUM_ELEMENTS).
// Clear item: a clearing pass, then a zero result. Reset: asynchronous, then a clearing pass.
module union_find_with_set_sizes_top #(
    parameter int NUM_ELEMENTS = ufs_pkg::DEFAULT_NUM_ELEMENTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            action,
    input  logic [ufs_pkg::INDEX_WIDTH-1:0] first_index,
    input  logic [ufs_pkg::INDEX_WIDTH-1:0] second_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ufs_pkg::SIZE_WIDTH-1:0]  group_size
);

    // Each table word packs the parent link, the member count and the rank of one element.
    // Only root words carry meaningful counts and ranks.
    localparam int IW = $clog2(NUM_ELEMENTS);
    localparam int CW = $clog2(NUM_ELEMENTS + 1);
    localparam int RW = ufs_pkg::RANK_WIDTH;
    localparam int SW = ufs_pkg::SIZE_WIDTH;
    localparam int DW = IW + CW + RW;
    localparam logic [31:0]   NUM_U    = 32'(NUM_ELEMENTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ELEMENTS - 1);

    // The block walks through a clearing pass, then serves items one at a time.
    // In a root search the read data of one node directly addresses
    // the read of its parent.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_CMP,
        S_LINK1,
        S_LINK2,
        S_OUT
    } state_t;

    state_t        state_reg;
    logic [IW-1:0] clr_reg;
    logic          clr_out_reg;
    logic          phase_reg;
    logic [IW-1:0] start_reg;
    logic [IW-1:0] cur_reg;
    logic [IW-1:0] b_reg;
    logic [IW-1:0] root_a_reg;
    logic [IW-1:0] root_b_reg;
    logic [CW-1:0] cnt_a_reg;
    logic [CW-1:0] cnt_b_reg;
    logic [RW-1:0] rank_a_reg;
    logic [RW-1:0] rank_b_reg;
    logic [CW-1:0] res_reg;
    logic          out_valid_reg;
    logic [SW-1:0] group_size_reg;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata;

    logic [IW-1:0] rd_par;
    logic [CW-1:0] rd_cnt;
    logic [RW-1:0] rd_rank;
    logic [IW-1:0] cur_root;
    logic          root_hit;
    logic          cmp_end;
    logic          find_done;
    logic          a_lower;
    logic [CW-1:0] link_sum;
    logic [RW-1:0] rank_up;
    logic [IW-1:0] a_in;
    logic [IW-1:0] b_in;
    logic          in_range;

    ufs_mem #(
        .DEPTH (NUM_ELEMENTS),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign a_in     = IW'(first_index);
    assign b_in     = IW'(second_index);
    assign in_range = (32'(first_index) < NUM_U) && (32'(second_index) < NUM_U);
    assign in_ready = (state_reg == S_IDLE);

    assign rd_par  = mem_rdata[DW-1 -: IW];
    assign rd_cnt  = mem_rdata[RW +: CW];
    assign rd_rank = mem_rdata[RW-1:0];

    // The root that the current search or compression pass works toward.
    assign cur_root  = phase_reg ? root_b_reg : root_a_reg;
    assign root_hit  = (rd_par == cur_reg);
    assign cmp_end   = (rd_par == cur_root);
    assign find_done = ((state_reg == S_FIND) && root_hit && (start_reg == cur_reg))
                    || ((state_reg == S_CMP) && cmp_end);

    // The root of lower rank goes under the other; on a tie the second root goes under
    // the first, whose rank then grows unless it is already saturated.
    assign a_lower  = (rank_a_reg < rank_b_reg);
    assign link_sum = cnt_a_reg + cnt_b_reg;
    assign rank_up  = ((rank_a_reg == rank_b_reg) && (rank_a_reg != ufs_pkg::RANK_MAX))
                    ? rank_a_reg + RW'(1) : rank_a_reg;

    // Read address: the next link of a search, the next node of a compression pass,
    // or the start of the second search once the first is finished.
    always_comb
    begin
        mem_raddr = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = a_in;
            end
            S_FIND:
            begin
                if (!root_hit)
                begin
                    mem_raddr = rd_par;
                end
                else
                begin
                    mem_raddr = start_reg;
                end
            end
            S_CMP:
            begin
                if (!cmp_end)
                begin
                    mem_raddr = rd_par;
                end
            end
            default:
            begin
                mem_raddr = cur_reg;
            end
        endcase
        if (find_done && !phase_reg)
        begin
            mem_raddr = b_reg;
        end
    end

    // Write port: clearing pass, compression of one node, or the two link writes.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = {cur_root, rd_cnt, rd_rank};
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {clr_reg, CW'(1), RW'(0)};
            end
            S_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = {cur_root, rd_cnt, rd_rank};
            end
            S_LINK1:
            begin
                mem_we = 1'b1;
                if (a_lower)
                begin
                    mem_waddr = root_a_reg;
                    mem_wdata = {root_b_reg, cnt_a_reg, rank_a_reg};
                end
                else
                begin
                    mem_waddr = root_b_reg;
                    mem_wdata = {root_a_reg, cnt_b_reg, rank_b_reg};
                end
            end
            S_LINK2:
            begin
                mem_we = 1'b1;
                if (a_lower)
                begin
                    mem_waddr = root_b_reg;
                    mem_wdata = {root_b_reg, link_sum, rank_b_reg};
                end
                else
                begin
                    mem_waddr = root_a_reg;
                    mem_wdata = {root_a_reg, link_sum, rank_up};
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            clr_out_reg    <= 1'b0;
            phase_reg      <= 1'b0;
            start_reg      <= '0;
            cur_reg        <= '0;
            b_reg          <= '0;
            root_a_reg     <= '0;
            root_b_reg     <= '0;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            rank_a_reg     <= '0;
            rank_b_reg     <= '0;
            res_reg        <= '0;
            out_valid_reg  <= 1'b0;
            group_size_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IW'(1);
                    if (clr_reg == LAST_IDX)
                    begin
                        clr_reg     <= '0;
                        clr_out_reg <= 1'b0;
                        res_reg     <= '0;
                        state_reg   <= clr_out_reg ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (action == ufs_pkg::ACT_CLEAR)
                        begin
                            clr_reg     <= '0;
                            clr_out_reg <= 1'b1;
                            state_reg   <= S_CLEAR;
                        end
                        else if (!in_range)
                        begin
                            res_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            phase_reg <= 1'b0;
                            start_reg <= a_in;
                            cur_reg   <= a_in;
                            b_reg     <= b_in;
                            state_reg <= S_FIND;
                        end
                    end
                end
                S_FIND:
                begin
                    if (!root_hit)
                    begin
                        cur_reg <= rd_par;
                    end
                    else
                    begin
                        if (phase_reg)
                        begin
                            root_b_reg <= cur_reg;
                            cnt_b_reg  <= rd_cnt;
                            rank_b_reg <= rd_rank;
                        end
                        else
                        begin
                            root_a_reg <= cur_reg;
                            cnt_a_reg  <= rd_cnt;
                            rank_a_reg <= rd_rank;
                        end
                        if (start_reg != cur_reg)
                        begin
                            cur_reg   <= start_reg;
                            state_reg <= S_CMP;
                        end
                    end
                end
                S_CMP:
                begin
                    if (!cmp_end)
                    begin
                        cur_reg <= rd_par;
                    end
                end
                S_LINK1:
                begin
                    state_reg <= S_LINK2;
                end
                S_LINK2:
                begin
                    res_reg   <= link_sum;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        group_size_reg <= SW'(res_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // End of a root search with its compression pass.
            if (find_done)
            begin
                if (!phase_reg)
                begin
                    phase_reg <= 1'b1;
                    start_reg <= b_reg;
                    cur_reg   <= b_reg;
                    state_reg <= S_FIND;
                end
                else
                begin
                    phase_reg <= 1'b0;
                    // Both searches have ended; the second root is known only now,
                    // so compare it as it is being captured.
                    if (((state_reg == S_FIND) ? cur_reg : root_b_reg) == root_a_reg)
                    begin
                        res_reg   <= cnt_a_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_LINK1;
                    end
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign group_size = group_size_reg;

`ifndef ASSERT_OFF
    // A compression write never lands on the node being read in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && !cmp_end) |-> (mem_waddr != mem_raddr))
        else $error("compression write collides with read address");

    // Linking only happens between two distinct roots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK1) |-> (root_a_reg != root_b_reg))
        else $error("link of a root with itself");

    // A merged count is larger than either part.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK2) |-> (link_sum > cnt_a_reg && link_sum > cnt_b_reg))
        else $error("member count overflow on link");

    // The clearing pass always leads to idle or to the zero result of a clear item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_reg == LAST_IDX)
            |=> ((state_reg == S_IDLE) || (state_reg == S_OUT && res_reg == '0)))
        else $error("clearing pass ended in a wrong state");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the disjoint-set table with per-set member counts.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ELEM    = ufs_pkg::DEFAULT_NUM_ELEMENTS;
    localparam int MAX_WAIT  = 19;
    // Tail after the drain; it covers the longest union with margin.
    localparam int TAIL_CYCLES = 64;

    typedef logic [ufs_pkg::INDEX_WIDTH-1:0] index_t;
    typedef logic [ufs_pkg::SIZE_WIDTH-1:0]  count_t;
    typedef logic [ufs_pkg::RANK_WIDTH-1:0]  rank_t;

    // Every input starts at a known value; reset is held from time zero.
    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   in_valid     = 1'b0;
    logic   action       = ufs_pkg::ACT_UNION;
    index_t first_index  = '0;
    index_t second_index = '0;
    logic   out_ready    = 1'b0;
    logic   in_ready;
    logic   out_valid;
    count_t group_size;

    // When set, both the sender and the receiver run without any idle cycles.
    bit no_gaps = 1'b0;
    int mismatches = 0;

    // Our own copy of the table: parent links, member counts and ranks.
    index_t link_of [N_ELEM];
    count_t size_of [N_ELEM];
    rank_t  rank_of [N_ELEM];

    // Set sizes that the block still owes us, oldest first.
    count_t expected_sizes[$];
    count_t want;

    union_find_with_set_sizes_top #(
        .NUM_ELEMENTS(N_ELEM)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .first_index  (first_index),
        .second_index (second_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .group_size   (group_size)
    );

    always #4 clk = ~clk;

    // Puts every element back into a singleton set, as reset and a clear item do.
    function automatic void reset_table();
        for (int i = 0; i < N_ELEM; i++)
        begin
            link_of[i] = index_t'(i);
            size_of[i] = count_t'(1);
            rank_of[i] = '0;
        end
    endfunction

    // Finds the root of an element, then points every element on the path at it.
    function automatic index_t find_root(input index_t e);
        index_t r;
        index_t cur;
        index_t nxt;
        int     steps;
        r = e;
        steps = 0;
        while (link_of[r] != r && steps < N_ELEM)
        begin
            r = link_of[r];
            steps++;
        end
        cur = e;
        steps = 0;
        while (cur != r && steps < N_ELEM)
        begin
            nxt = link_of[cur];
            link_of[cur] = r;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    // Applies one item to our table and returns the set size the block should report.
    function automatic count_t predict_group_size(input logic act, input index_t a,
                                                  input index_t b);
        index_t ra;
        index_t rb;
        if (act == ufs_pkg::ACT_CLEAR)
        begin
            reset_table();
            return '0;
        end
        // An index past the end of the table leaves everything untouched.
        if (int'(a) >= N_ELEM || int'(b) >= N_ELEM)
            return '0;
        ra = find_root(a);
        rb = find_root(b);
        if (ra == rb)
            return size_of[ra];
        if (rank_of[ra] < rank_of[rb])
        begin
            link_of[ra] = rb;
            size_of[rb] = size_of[rb] + size_of[ra];
            return size_of[rb];
        end
        // Equal or higher rank: the second root goes under the first.
        link_of[rb] = ra;
        if (rank_of[ra] == rank_of[rb] && rank_of[ra] < ufs_pkg::RANK_MAX)
            rank_of[ra] = rank_of[ra] + 1'b1;
        size_of[ra] = size_of[ra] + size_of[rb];
        return size_of[ra];
    endfunction

    // Scoreboard. An accepted item is run through our table right away, so the
    // expectation is queued long before the block can answer it. Every result that
    // leaves the block is matched against the oldest queued size.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid === 1'b1 && in_ready === 1'b1)
                expected_sizes.push_back(predict_group_size(action, first_index,
                                                            second_index));
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (expected_sizes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got group_size %0d",
                             $time, group_size);
                    mismatches++;
                end
                else
                begin
                    want = expected_sizes.pop_front();
                    if (group_size !== want)
                    begin
                        $display("%0t: group_size mismatch, expected %0d, got %0d",
                                 $time, want, group_size);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result side. Before each result the receiver holds ready low for a random
    // number of cycles, then keeps it high until a result is taken. With a zero
    // draw ready simply stays high, so back-to-back results are possible.
    initial
    begin
        int stall;
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1);
        end
    end

    // Sends one item. The idle gap comes first; with no gap, valid stays high from
    // the previous item and only the payload changes. Returns at the accepting edge.
    task automatic issue_item(input logic act, input index_t a, input index_t b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action       <= act;
        first_index  <= a;
        second_index <= b;
        in_valid     <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
    endtask

    // Hand-picked items: index extremes, a repeated element, sets that are already
    // joined, both rank orders, equal ranks, and clears with arbitrary index fields.
    task automatic test_directed_cases();
        issue_item(ufs_pkg::ACT_CLEAR, 10'd1023, 10'd1023);
        issue_item(ufs_pkg::ACT_UNION, 10'd0, 10'd0);
        issue_item(ufs_pkg::ACT_UNION, 10'd1023, 10'd1023);
        issue_item(ufs_pkg::ACT_UNION, 10'd0, 10'd1023);
        issue_item(ufs_pkg::ACT_UNION, 10'd1023, 10'd0);
        issue_item(ufs_pkg::ACT_UNION, 10'd1, 10'd2);
        issue_item(ufs_pkg::ACT_UNION, 10'd2, 10'd0);
        // A singleton joined with a rank-two tree hangs under that tree.
        issue_item(ufs_pkg::ACT_UNION, 10'd3, 10'd1023);
        issue_item(ufs_pkg::ACT_UNION, 10'd1022, 10'd5);
        issue_item(ufs_pkg::ACT_UNION, 10'd6, 10'd1022);
        // Lower-rank first root, so the first set goes under the second.
        issue_item(ufs_pkg::ACT_UNION, 10'd1022, 10'd3);
        issue_item(ufs_pkg::ACT_UNION, 10'd512, 10'd511);
        issue_item(ufs_pkg::ACT_UNION, 10'd341, 10'd682);
        issue_item(ufs_pkg::ACT_UNION, 10'd511, 10'd682);
        issue_item(ufs_pkg::ACT_UNION, 10'd682, 10'd1);
        issue_item(ufs_pkg::ACT_UNION, 10'd5, 10'd511);
        issue_item(ufs_pkg::ACT_CLEAR, 10'd341, 10'd682);
        issue_item(ufs_pkg::ACT_UNION, 10'd0, 10'd1023);
        issue_item(ufs_pkg::ACT_UNION, 10'd0, 10'd0);
        issue_item(ufs_pkg::ACT_UNION, 10'd1023, 10'd2);
        issue_item(ufs_pkg::ACT_CLEAR, 10'd0, 10'd0);
        issue_item(ufs_pkg::ACT_UNION, 10'd682, 10'd341);
    endtask

    // Builds one balanced tree over a 256-element window by joining equal-rank
    // halves level by level, which drives the root rank up to eight and leaves
    // long paths for compression. Random members, not roots, name each half.
    task automatic test_rank_tree_build();
        int base;
        int s;
        int lo;
        int hi;
        base = $urandom_range(0, 3) * 256;
        issue_item(ufs_pkg::ACT_CLEAR, index_t'($urandom), index_t'($urandom));
        for (s = 1; s < 256; s = s * 2)
        begin
            for (int blk = 0; blk < 256; blk += 2 * s)
            begin
                lo = base + blk + $urandom_range(0, s - 1);
                hi = base + blk + s + $urandom_range(0, s - 1);
                if ($urandom_range(0, 1) == 0)
                    issue_item(ufs_pkg::ACT_UNION, index_t'(lo), index_t'(hi));
                else
                    issue_item(ufs_pkg::ACT_UNION, index_t'(hi), index_t'(lo));
            end
        end
        // Queries inside the finished set walk and flatten the deep paths.
        repeat (16)
            issue_item(ufs_pkg::ACT_UNION, index_t'(base + $urandom_range(0, 255)),
                       index_t'(base + $urandom_range(0, 255)));
        // A singleton from outside the window goes under the big root.
        issue_item(ufs_pkg::ACT_UNION,
                   index_t'((base + 256 + $urandom_range(0, 767)) % N_ELEM),
                   index_t'(base + $urandom_range(0, 255)));
    endtask

    // Random phases. Most unions draw both indices from a small pool so sets grow
    // and merge repeatedly; some pools are wide or span the whole table. Mixed in
    // are swapped repeats of the previous pair, repeated elements, full-range unions and
    // occasional clears. About one phase in six runs with no idle cycles at all.
    task automatic test_random_unions(input int item_goal);
        int     sent;
        int     phase_len;
        int     pool;
        int     base;
        int     pick;
        logic   act;
        index_t a;
        index_t b;
        index_t last_a;
        index_t last_b;
        sent = 0;
        last_a = '0;
        last_b = '0;
        while (sent < item_goal)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            phase_len = $urandom_range(20, 80);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                pool = $urandom_range(2, 48);
            else if (pick < 9)
                pool = $urandom_range(49, 256);
            else
                pool = N_ELEM;
            base = $urandom_range(0, N_ELEM - pool);
            repeat (phase_len)
            begin
                pick = $urandom_range(0, 99);
                act = ufs_pkg::ACT_UNION;
                if (pick < 2)
                begin
                    act = ufs_pkg::ACT_CLEAR;
                    a = index_t'($urandom);
                    b = index_t'($urandom);
                end
                else if (pick < 7)
                begin
                    a = index_t'($urandom);
                    b = index_t'($urandom);
                end
                else if (pick < 12)
                begin
                    a = last_b;
                    b = last_a;
                end
                else if (pick < 15)
                begin
                    a = index_t'(base + $urandom_range(0, pool - 1));
                    b = a;
                end
                else
                begin
                    a = index_t'(base + $urandom_range(0, pool - 1));
                    b = index_t'(base + $urandom_range(0, pool - 1));
                end
                issue_item(act, a, b);
                last_a = a;
                last_b = b;
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // Main sequence: reset once, run the tests in turn, drain, then report.
    initial
    begin
        reset_table();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_rank_tree_build();
        test_random_unions(1100);

        // Let the scoreboard see the last acceptance, then drop valid and wait
        // until every queued size has come back, plus a tail for stray results.
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_sizes.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog. A correct run, clears and the post-reset clearing pass included,
    // ends far short of 10 ms of simulated time.
    initial
    begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_sizes.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
